// ----- rtl/obsc_pkg.sv -----
// ----------------------------------------------------------------------------
// obsc_pkg
// Shared types and constants of the OSC bundle sanity checker.
// ----------------------------------------------------------------------------
package obsc_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned HeaderBytes   = 16;
  localparam int unsigned IdBytes       = 8;
  localparam int unsigned LenInWidth    = 16;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned VerdictWidth  = 3;
  localparam int unsigned SizeWidth     = 32;
  localparam int unsigned EndWidth      = 34;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [ByteWidth-1:0] SLASH_CHAR = 8'h2f;
  localparam logic signed [SizeWidth-1:0] MIN_MSG_SIZE = 32'sd4;

  typedef enum logic [VerdictWidth-1:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_TOO_SMALL = 3'd1,
    VERDICT_NO_ID     = 3'd2,
    VERDICT_MSG_LARGE = 3'd3,
    VERDICT_MSG_SMALL = 3'd4,
    VERDICT_BAD_ADDR  = 3'd5
  } verdict_e;

  typedef struct packed {
    logic                  cmd;
    logic [LenInWidth-1:0] bundle_length;
    logic [ByteWidth-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic     emit;
    verdict_e verdict;
  } result_t;

  // bundle id "#bundle" followed by a zero byte
  function automatic logic [ByteWidth-1:0] tag_byte(input logic [2:0] idx);
    logic [ByteWidth-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h23;
      3'd1:    b = 8'h62;
      3'd2:    b = 8'h75;
      3'd3:    b = 8'h6e;
      3'd4:    b = 8'h64;
      3'd5:    b = 8'h6c;
      3'd6:    b = 8'h65;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/obsc_if.sv -----
// ----------------------------------------------------------------------------
// obsc_if
// Valid/ready channels of the OSC bundle sanity checker.
// ----------------------------------------------------------------------------
interface obsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [obsc_pkg::LenInWidth-1:0]      bundle_length;
  logic [obsc_pkg::ByteWidth-1:0]       data_byte;

  modport source (output valid, cmd, bundle_length, data_byte, input ready);
  modport sink   (input valid, cmd, bundle_length, data_byte, output ready);
endinterface

interface obsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [obsc_pkg::VerdictWidth-1:0]    verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ----- rtl/obsc_in_stage.sv -----
// ----------------------------------------------------------------------------
// obsc_in_stage
// Input register; hands one item a cycle to the check logic when the
// result register has room.
// ----------------------------------------------------------------------------
module obsc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  obsc_in_if.sink        in_i,
  input  logic           out_free_i,
  output logic           advance_o,
  output obsc_pkg::item_t item_o
);

  logic            valid_q;
  logic            valid_d;
  logic            accept;
  obsc_pkg::item_t item_q;

  assign advance_o  = valid_q && out_free_i;
  assign in_i.ready = !valid_q || advance_o;
  assign accept     = in_i.valid && in_i.ready;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd           <= in_i.cmd;
      item_q.bundle_length <= in_i.bundle_length;
      item_q.data_byte     <= in_i.data_byte;
    end
  end

endmodule

// ----- rtl/obsc_check.sv -----
// ----------------------------------------------------------------------------
// obsc_check
// Bundle parse state and the per-byte checks; gives at most one verdict
// per item.
// ----------------------------------------------------------------------------
module obsc_check #(
  parameter int unsigned LENGTH_BITS = obsc_pkg::LengthBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  obsc_pkg::item_t   item_i,
  output obsc_pkg::result_t result_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_TIME = 3'd2;
  localparam logic [2:0] PH_SIZE = 3'd3;
  localparam logic [2:0] PH_ADDR = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;

  localparam int unsigned EW = obsc_pkg::EndWidth;

  logic [2:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] off_q, off_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] mend_q, mend_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [23:0]            sg_q, sg_d;

  logic [LENGTH_BITS+15:0] len_wide;
  logic [LENGTH_BITS-1:0]  len_in;
  logic [LENGTH_BITS:0]    off_inc;
  logic                    last;
  logic                    body_end;
  logic [obsc_pkg::SizeWidth-1:0] size;
  logic [EW-1:0]           end_sum;
  obsc_pkg::result_t       res;

  assign len_wide = {LENGTH_BITS'(0), item_i.bundle_length};
  assign len_in   = len_wide[LENGTH_BITS-1:0];
  assign off_inc  = {1'b0, off_q} + (LENGTH_BITS+1)'(1);
  assign last     = off_inc == {1'b0, len_q};
  assign body_end = off_inc == {1'b0, mend_q};
  assign size     = {sg_q, item_i.data_byte};
  assign end_sum  = EW'(off_q) + EW'(1) + {{(EW-obsc_pkg::SizeWidth){size[31]}}, size};

  always_comb begin
    phase_d     = phase_q;
    off_d       = off_q;
    len_d       = len_q;
    mend_d      = mend_q;
    cnt_d       = cnt_q;
    sg_d        = sg_q;
    res.emit    = 1'b0;
    res.verdict = obsc_pkg::VERDICT_OK;
    if (advance_i) begin
      if (item_i.cmd == obsc_pkg::CMD_START) begin
        len_d  = len_in;
        off_d  = '0;
        mend_d = '0;
        if (len_in < LENGTH_BITS'(obsc_pkg::HeaderBytes)) begin
          res.emit    = 1'b1;
          res.verdict = obsc_pkg::VERDICT_TOO_SMALL;
          phase_d     = PH_IDLE;
        end else begin
          phase_d = PH_ID;
        end
      end else if (phase_q != PH_IDLE) begin
        off_d = off_inc[LENGTH_BITS-1:0];
        unique case (phase_q) inside
          PH_ID: begin
            if (item_i.data_byte != obsc_pkg::tag_byte(off_q[2:0])) begin
              res.emit    = 1'b1;
              res.verdict = obsc_pkg::VERDICT_NO_ID;
              phase_d     = PH_IDLE;
            end else if (off_q >= LENGTH_BITS'(obsc_pkg::IdBytes - 1)) begin
              phase_d = PH_TIME;
            end
          end
          PH_TIME: begin
            if (off_q >= LENGTH_BITS'(obsc_pkg::HeaderBytes - 1)) begin
              if (last) begin
                res.emit = 1'b1;
                phase_d  = PH_IDLE;
              end else begin
                phase_d = PH_SIZE;
                cnt_d   = 2'd0;
              end
            end
          end
          PH_SIZE: begin
            sg_d = {sg_q[15:0], item_i.data_byte};
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
              if (last) begin
                res.emit    = 1'b1;
                res.verdict = obsc_pkg::VERDICT_MSG_LARGE;
                phase_d     = PH_IDLE;
              end
            end else if ($signed(end_sum) > $signed(EW'(len_q))) begin
              res.emit    = 1'b1;
              res.verdict = obsc_pkg::VERDICT_MSG_LARGE;
              phase_d     = PH_IDLE;
            end else if ($signed(size) < obsc_pkg::MIN_MSG_SIZE) begin
              res.emit    = 1'b1;
              res.verdict = obsc_pkg::VERDICT_MSG_SMALL;
              phase_d     = PH_IDLE;
            end else begin
              phase_d = PH_ADDR;
              mend_d  = end_sum[LENGTH_BITS-1:0];
            end
          end
          PH_ADDR, PH_BODY: begin
            if (phase_q == PH_ADDR && item_i.data_byte != obsc_pkg::SLASH_CHAR) begin
              res.emit    = 1'b1;
              res.verdict = obsc_pkg::VERDICT_BAD_ADDR;
              phase_d     = PH_IDLE;
            end else begin
              phase_d = PH_BODY;
              if (body_end) begin
                if (last) begin
                  res.emit = 1'b1;
                  phase_d  = PH_IDLE;
                end else begin
                  phase_d = PH_SIZE;
                  cnt_d   = 2'd0;
                end
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      off_q   <= '0;
      len_q   <= '0;
      mend_q  <= '0;
      cnt_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      len_q   <= len_d;
      mend_q  <= mend_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sg_q <= sg_d;
  end

endmodule

// ----- rtl/obsc_out_stage.sv -----
// ----------------------------------------------------------------------------
// obsc_out_stage
// Result register holding one verdict until the sink takes it.
// ----------------------------------------------------------------------------
module obsc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  obsc_pkg::result_t result_i,
  output logic              out_free_o,
  obsc_out_if.source        out_o
);

  logic                   valid_q;
  logic                   valid_d;
  obsc_pkg::verdict_e     verdict_q;

  assign out_free_o    = !valid_q || out_o.ready;
  assign out_o.valid   = valid_q;
  assign out_o.verdict = verdict_q;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = result_i.emit;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && result_i.emit) begin
      verdict_q <= result_i.verdict;
    end
  end

endmodule

// ----- rtl/osc_bundle_sanity_checker_core.sv -----
// ----------------------------------------------------------------------------
// osc_bundle_sanity_checker_core
// Byte-serial OSC bundle checker with one verdict per bundle.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries either a start transaction (cmd 0, bundle_length) or one
//   bundle byte (cmd 1, data_byte), in bundle order. out_o carries a single
//   verdict per bundle: the first failure found, or ok at the last byte.
//   Bytes after a verdict are dropped until the next start; a start in the
//   middle of a bundle abandons it without a verdict.
// Timing:
//   Every transaction passes an input register and the check logic, then
//   the verdict lands in the result register, which drives out_o.valid;
//   throughput is one transaction per cycle while out_o is not stalled,
//   limited by the single parse-state update per byte.
// Reset:
//   rst_ni clears the valid flags of both registers and puts the parser
//   idle; the first transaction expected is a start.
// Stall:
//   While a verdict waits on out_o, the next transaction is still taken
//   into the input register; in_i.ready drops only when both hold data.
// ----------------------------------------------------------------------------
module osc_bundle_sanity_checker_core #(
  parameter int unsigned LENGTH_BITS = obsc_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  obsc_in_if.sink     in_i,
  obsc_out_if.source  out_o
);

  logic              advance;
  logic              out_free;
  obsc_pkg::item_t   item;
  obsc_pkg::result_t result;

  obsc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .advance_o  (advance),
    .item_o     (item)
  );

  obsc_check #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  obsc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .result_i   (result),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

// ----- rtl/obsc_sva.sv -----
// ----------------------------------------------------------------------------
// obsc_sva
// Port-level checks for the OSC bundle sanity checker.
// ----------------------------------------------------------------------------
module obsc_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [obsc_pkg::VerdictWidth-1:0] out_verdict
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_verdict))
    else $error("verdict changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_verdict <= obsc_pkg::VERDICT_BAD_ADDR)
    else $error("verdict code out of range");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

endmodule

bind osc_bundle_sanity_checker_core obsc_sva u_obsc_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_verdict (out_o.verdict)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OSC bundle sanity checker: a directed table of
// short bundles, then random bundles (mostly well formed, some corrupted or
// cut off) under several idle/stall mixes, each verdict compared against the
// table's expectation or a byte-level parser model kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LENGTH_BITS = obsc_pkg::LengthBitsDef;
  localparam logic [31:0] LenMask     = (32'd1 << LENGTH_BITS) - 32'd1;
  localparam logic [63:0] BundleTag   = {"#bundle", 8'h00};
  localparam logic [7:0]  SlashByte   = 8'h2f;
  localparam int          StallLimit  = 2000;
  localparam int          PhaseItems  = 375;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ID, ST_TIME, ST_SIZE, ST_ADDR, ST_BODY
  } parse_e;

  typedef enum logic [1:0] {
    STEP_PREDICT, STEP_NO_VERDICT, STEP_VERDICT
  } step_kind_e;

  typedef struct packed {
    logic                            cmd;
    logic [obsc_pkg::LenInWidth-1:0] len;
    logic [obsc_pkg::ByteWidth-1:0]  dbyte;
    step_kind_e                      kind;
    obsc_pkg::verdict_e              verdict;
  } step_t;

  logic clk_i;
  logic rst_ni;

  obsc_in_if  in_if ();
  obsc_out_if out_if ();

  osc_bundle_sanity_checker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // parser model state
  parse_e      parse_st  = ST_IDLE;
  logic [15:0] next_off  = '0;
  logic [15:0] len_held  = '0;
  logic [31:0] size_acc  = '0;
  longint      msg_end   = 0;

  step_t              pending_steps[$];
  obsc_pkg::verdict_e expected_verdicts[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned stall_cycles   = 0;
  int unsigned items_in       = 0;
  int unsigned live_items     = 0;
  int unsigned verdicts_out   = 0;
  int unsigned verdict_hist[8];

  step_t directed_steps[25] = '{
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h23, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_START, 16'd0,    8'h00, STEP_VERDICT,    obsc_pkg::VERDICT_TOO_SMALL},
    '{obsc_pkg::CMD_START, 16'd15,   8'h00, STEP_VERDICT,    obsc_pkg::VERDICT_TOO_SMALL},
    '{obsc_pkg::CMD_START, 16'hffff, 8'h00, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h23, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h00, STEP_VERDICT,    obsc_pkg::VERDICT_NO_ID},
    '{obsc_pkg::CMD_START, 16'd16,   8'hff, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'hffff, 8'h23, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    // restart in the middle of a bundle, then an exactly header-sized one
    '{obsc_pkg::CMD_START, 16'd16,   8'h00, STEP_NO_VERDICT, obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h23, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h62, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h75, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h6e, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h64, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h6c, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h65, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'h00, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_PREDICT,    obsc_pkg::VERDICT_OK},
    '{obsc_pkg::CMD_DATA,  16'd0,    8'hff, STEP_VERDICT,    obsc_pkg::VERDICT_OK}
  };

  function automatic bit parse_byte(input obsc_pkg::item_t it,
                                    output obsc_pkg::verdict_e v);
    logic [15:0] off;
    logic [7:0]  b;
    logic [31:0] cnt;
    bit          last;
    bit          emit;
    bit          body_done;
    longint      sz;
    v         = obsc_pkg::VERDICT_OK;
    emit      = 1'b0;
    body_done = 1'b0;
    if (it.cmd == obsc_pkg::CMD_START) begin
      len_held = 16'(32'(it.bundle_length) & LenMask);
      next_off = '0;
      size_acc = '0;
      msg_end  = 0;
      if (32'(len_held) < obsc_pkg::HeaderBytes) begin
        parse_st = ST_IDLE;
        v        = obsc_pkg::VERDICT_TOO_SMALL;
        return 1'b1;
      end
      parse_st = ST_ID;
      return 1'b0;
    end
    if (parse_st == ST_IDLE) return 1'b0;
    b        = it.data_byte;
    off      = next_off;
    last     = (32'(off) + 32'd1 == 32'(len_held));
    next_off = 16'((32'(off) + 32'd1) & LenMask);
    case (parse_st)
      ST_ID: begin
        if (b != BundleTag[63 - 8*off[2:0] -: 8]) begin
          emit = 1'b1;
          v    = obsc_pkg::VERDICT_NO_ID;
        end else if (32'(off) >= obsc_pkg::IdBytes - 1) begin
          parse_st = ST_TIME;
        end
      end
      ST_TIME: begin
        if (32'(off) >= obsc_pkg::HeaderBytes - 1) begin
          if (last) begin
            emit = 1'b1;
          end else begin
            parse_st = ST_SIZE;
            msg_end  = obsc_pkg::HeaderBytes;
            size_acc = '0;
          end
        end
      end
      ST_SIZE: begin
        size_acc = {size_acc[23:0], b};
        cnt      = 32'(longint'(off) - msg_end);
        if (cnt < 32'd3) begin
          if (last) begin
            emit = 1'b1;
            v    = obsc_pkg::VERDICT_MSG_LARGE;
          end
        end else begin
          sz      = longint'($signed(size_acc));
          msg_end = msg_end + 4 + sz;
          if (msg_end > longint'(len_held)) begin
            emit = 1'b1;
            v    = obsc_pkg::VERDICT_MSG_LARGE;
          end else if (sz < 4) begin
            emit = 1'b1;
            v    = obsc_pkg::VERDICT_MSG_SMALL;
          end else begin
            parse_st = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        if (b != SlashByte) begin
          emit = 1'b1;
          v    = obsc_pkg::VERDICT_BAD_ADDR;
        end else begin
          parse_st  = ST_BODY;
          body_done = 1'b1;
        end
      end
      ST_BODY: begin
        body_done = 1'b1;
      end
      default: parse_st = ST_IDLE;
    endcase
    if (body_done && longint'(off) + 1 == msg_end) begin
      if (last) begin
        emit = 1'b1;
      end else begin
        parse_st = ST_SIZE;
        msg_end  = longint'(off) + 1;
        size_acc = '0;
      end
    end
    if (emit) parse_st = ST_IDLE;
    return emit;
  endfunction

  function automatic step_t rand_step(input logic cmd, input logic [15:0] len,
                                      input logic [7:0] dbyte);
    step_t s;
    s.cmd     = cmd;
    s.len     = (cmd == obsc_pkg::CMD_START) ? len : 16'($urandom);
    s.dbyte   = (cmd == obsc_pkg::CMD_DATA) ? dbyte : 8'($urandom);
    s.kind    = STEP_PREDICT;
    s.verdict = obsc_pkg::VERDICT_OK;
    return s;
  endfunction

  task automatic drive_step(input step_t s);
    pending_steps.push_back(s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cmd           <= s.cmd;
    in_if.bundle_length <= s.len;
    in_if.data_byte     <= s.dbyte;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_bundle();
    logic [7:0]  bytes_q[$];
    logic [31:0] size_field;
    int unsigned n_msgs;
    int unsigned body_len;
    int unsigned roll;
    int unsigned idx;
    int          len_field;
    int          cut;
    bytes_q = {};
    for (int i = 0; i < 8; i++) bytes_q.push_back(BundleTag[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) bytes_q.push_back(8'($urandom));
    n_msgs = $urandom_range(0, 3);
    for (int m = 0; m < n_msgs; m++) begin
      body_len = $urandom_range(4, 9);
      roll     = $urandom_range(0, 99);
      if (roll < 5) size_field = $urandom;
      else if (roll < 9) size_field = $urandom_range(0, 3);
      else size_field = body_len;
      for (int k = 3; k >= 0; k--) bytes_q.push_back(size_field[8*k +: 8]);
      if ($urandom_range(0, 99) < 5) bytes_q.push_back(8'($urandom));
      else bytes_q.push_back(SlashByte);
      for (int k = 1; k < body_len; k++) bytes_q.push_back(8'($urandom));
    end
    len_field = bytes_q.size();
    roll      = $urandom_range(0, 99);
    if (roll < 6) begin
      idx          = $urandom_range(0, 7);
      bytes_q[idx] = bytes_q[idx] ^ 8'($urandom_range(1, 255));
    end else if (roll < 14) begin
      len_field = len_field + int'($urandom_range(0, 12)) - 6;
    end else if (roll < 26) begin
      len_field = $urandom_range(0, 65535);
    end else if (roll < 30) begin
      len_field = $urandom_range(0, 15);
    end else if (roll < 36) begin
      // size field cut short by the bundle end
      repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom));
      len_field = bytes_q.size();
    end
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) bytes_q.push_back(8'($urandom));
    end
    cut = bytes_q.size();
    if ($urandom_range(0, 99) < 8) cut = $urandom_range(0, bytes_q.size());
    drive_step(rand_step(obsc_pkg::CMD_START, 16'(len_field), 8'h00));
    for (int i = 0; i < cut; i++) begin
      drive_step(rand_step(obsc_pkg::CMD_DATA, 16'h0000, bytes_q[i]));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    obsc_pkg::item_t    it;
    step_t              s;
    obsc_pkg::verdict_e pv;
    obsc_pkg::verdict_e want;
    parse_e             was;
    bit                 emit;
    bit                 moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        moved            = 1'b1;
        it.cmd           = in_if.cmd;
        it.bundle_length = in_if.bundle_length;
        it.data_byte     = in_if.data_byte;
        s                = pending_steps.pop_front();
        was              = parse_st;
        emit             = parse_byte(it, pv);
        items_in++;
        if (it.cmd == obsc_pkg::CMD_START || was != ST_IDLE) live_items++;
        case (s.kind)
          STEP_PREDICT: if (emit) expected_verdicts.push_back(pv);
          STEP_VERDICT: expected_verdicts.push_back(s.verdict);
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        verdicts_out++;
        verdict_hist[out_if.verdict]++;
        if (expected_verdicts.size() == 0) begin
          $error("verdict: expected none, got %0d", out_if.verdict);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.verdict !== want) begin
            $error("verdict: expected %0d, got %0d", want, out_if.verdict);
            errors++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < StallLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_end;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.cmd           = obsc_pkg::CMD_START;
    in_if.bundle_length = '0;
    in_if.data_byte     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_steps[i]) drive_step(directed_steps[i]);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_end = items_in + PhaseItems;
      while (items_in < phase_end) send_bundle();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run: %0d transactions in, %0d seen by the parser, %0d verdicts out",
             items_in, live_items, verdicts_out);
    $display({"verdicts: ok %0d, short bundle %0d, no id %0d, msg large %0d, ",
              "msg small %0d, bad addr %0d"},
             verdict_hist[obsc_pkg::VERDICT_OK],
             verdict_hist[obsc_pkg::VERDICT_TOO_SMALL],
             verdict_hist[obsc_pkg::VERDICT_NO_ID],
             verdict_hist[obsc_pkg::VERDICT_MSG_LARGE],
             verdict_hist[obsc_pkg::VERDICT_MSG_SMALL],
             verdict_hist[obsc_pkg::VERDICT_BAD_ADDR]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/obsc_pkg.sv
rtl/obsc_if.sv
rtl/obsc_in_stage.sv
rtl/obsc_check.sv
rtl/obsc_out_stage.sv
rtl/osc_bundle_sanity_checker_core.sv
rtl/obsc_sva.sv
tb/tb.sv
